// ===== rtl/pts_pkg.sv =====
// Shared codes and types for the priority thread scheduler.
package pts_pkg;

   // operation codes
   localparam logic [2:0] OP_ADD   = 3'd0;
   localparam logic [2:0] OP_START = 3'd1;
   localparam logic [2:0] OP_TICK  = 3'd2;
   localparam logic [2:0] OP_SLEEP = 3'd3;
   localparam logic [2:0] OP_SCHED = 3'd4;

   // response status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;
   localparam logic [1:0] STATUS_IDLE  = 2'd3;

   // slot states
   localparam logic [1:0] SLOT_READY    = 2'd0;
   localparam logic [1:0] SLOT_RUNNING  = 2'd1;
   localparam logic [1:0] SLOT_SLEEPING = 2'd2;

   // per-cell command, decoded by the top level
   typedef struct packed {
      logic        active;   // slot index below the fill count
      logic        late;     // slot index at or below the current slot
      logic        tick;
      logic        wr;       // add: load priority, mark ready
      logic        run;      // become running
      logic        unrun;    // running -> ready
      logic        sleep;    // load sleep count, mark sleeping
      logic [7:0]  prio;
      logic [31:0] ticks;
   } slot_cmd_type;

   // best-so-far candidate passed down the chain
   typedef struct packed {
      logic       found;
      logic       late;
      logic [7:0] prio;
   } scan_cand_type;

endpackage

// ===== rtl/priority_thread_scheduler_top.sv =====
// Top level of the priority thread scheduler: command decode, slot chain, response.
//
// Usage:
//  - Command channel: drive req_operation, req_priority_req and req_sleep_ticks
//    with start high; the beat is taken on a rising edge where busy is low.
//  - Response channel: one response beat per command. rsp_valid is high for
//    exactly one cycle with rsp_status, rsp_assigned_slot, rsp_running_slot,
//    rsp_running_valid and rsp_switched; the receiver cannot stall it.
//  - Sequencing: an accepted beat is latched and the block enters the work state;
//    add, start, tick and sleep commit at once, schedule once the chain settles.
//    busy falls together with the response strobe, so a new command may be
//    accepted in the response cycle, but not while a command is in flight.
//  - The schedule time is set by the slot chain: the best candidate moves one
//    cell per cycle from slot 0 to the last slot, and the result is read at
//    the chain tail once every stage has settled.
//  - Reset (synchronous, active high) empties the slot table and clears the
//    current slot; slot contents are not cleared and are rewritten by add.
module priority_thread_scheduler_top #(
   parameter int unsigned MAX_SLOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_operation,
   input  logic [7:0]  req_priority_req,
   input  logic [31:0] req_sleep_ticks,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_assigned_slot,
   output logic [2:0]  rsp_running_slot,
   output logic        rsp_running_valid,
   output logic        rsp_switched
);
   import pts_pkg::*;

   localparam int unsigned IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 1);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_WORK = 1'b1;

   // control
   logic             fsm_ff, fsm_in;
   logic [CNT_W-1:0] wait_ff, wait_in;
   logic [CNT_W-1:0] slot_count_ff, slot_count_in;
   logic [IDX_W-1:0] cur_slot_ff, cur_slot_in;
   logic             cur_valid_ff, cur_valid_in;

   // latched command beat
   logic [2:0]  op_ff;
   logic [7:0]  prio_ff;
   logic [31:0] ticks_ff;

   // response registers
   logic       rsp_valid_ff;
   logic [1:0] rsp_status_ff;
   logic [2:0] rsp_assigned_ff;
   logic [2:0] rsp_running_ff;
   logic       rsp_running_valid_ff;
   logic       rsp_switched_ff;

   logic accept, commit;

   // decoded slot actions
   logic             wr_en, run_en, unrun_en, sleep_en, tick_en;
   logic [IDX_W-1:0] run_idx;
   logic [1:0]       status_w;
   logic             switched_w;

   // slot chain
   scan_cand_type    cand_w [MAX_SLOTS+1];
   logic [IDX_W-1:0] cidx_w [MAX_SLOTS+1];
   slot_cmd_type     cmd_w  [MAX_SLOTS];

   assign busy   = fsm_ff;
   assign accept = start && !busy;
   assign commit = (fsm_ff == S_WORK) && (wait_ff == '0);

   // sequencing: schedule waits for the chain to settle, other ops commit at once
   always_comb begin
      fsm_in  = fsm_ff;
      wait_in = wait_ff;
      unique case (fsm_ff)
         S_IDLE: begin
            if (accept) begin
               fsm_in  = S_WORK;
               wait_in = (req_operation == OP_SCHED) ? CNT_W'(MAX_SLOTS) : '0;
            end
         end
         S_WORK: begin
            if (wait_ff == '0) fsm_in = S_IDLE;
            else wait_in = wait_ff - CNT_W'(1);
         end
         default: fsm_in = S_IDLE;
      endcase
   end

   // operation decode at commit
   always_comb begin
      wr_en         = 1'b0;
      run_en        = 1'b0;
      unrun_en      = 1'b0;
      sleep_en      = 1'b0;
      tick_en       = 1'b0;
      run_idx       = '0;
      status_w      = STATUS_OK;
      switched_w    = 1'b0;
      slot_count_in = slot_count_ff;
      cur_slot_in   = cur_slot_ff;
      cur_valid_in  = cur_valid_ff;
      if (commit) begin
         unique case (op_ff)
            OP_ADD: begin
               if (slot_count_ff == CNT_W'(MAX_SLOTS)) begin
                  status_w = STATUS_FULL;
               end else begin
                  wr_en         = 1'b1;
                  slot_count_in = slot_count_ff + CNT_W'(1);
               end
            end
            OP_START: begin
               if (slot_count_ff == '0) begin
                  status_w = STATUS_EMPTY;
               end else begin
                  run_en       = 1'b1;
                  run_idx      = '0;
                  unrun_en     = cur_valid_ff && (cur_slot_ff != '0);
                  cur_slot_in  = '0;
                  cur_valid_in = 1'b1;
               end
            end
            OP_TICK: tick_en = 1'b1;
            OP_SLEEP: begin
               if (!cur_valid_ff) status_w = STATUS_IDLE;
               else sleep_en = 1'b1;
            end
            OP_SCHED: begin
               if (slot_count_ff == '0) begin
                  status_w = STATUS_EMPTY;
               end else if (cand_w[MAX_SLOTS].found) begin
                  run_en       = 1'b1;
                  run_idx      = cidx_w[MAX_SLOTS];
                  unrun_en     = cur_valid_ff && (cur_slot_ff != cidx_w[MAX_SLOTS]);
                  switched_w   = !cur_valid_ff || (cur_slot_ff != cidx_w[MAX_SLOTS]);
                  cur_slot_in  = cidx_w[MAX_SLOTS];
                  cur_valid_in = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // chain head: nothing found yet
   assign cand_w[0] = '0;
   assign cidx_w[0] = '0;

   for (genvar k = 0; k < MAX_SLOTS; k++) begin : g_slot
      always_comb begin
         cmd_w[k].active = CNT_W'(k) < slot_count_ff;
         cmd_w[k].late   = IDX_W'(k) <= cur_slot_ff;
         cmd_w[k].tick   = tick_en;
         cmd_w[k].wr     = wr_en && (slot_count_ff[IDX_W-1:0] == IDX_W'(k));
         cmd_w[k].run    = run_en && (run_idx == IDX_W'(k));
         cmd_w[k].unrun  = unrun_en && (cur_slot_ff == IDX_W'(k));
         cmd_w[k].sleep  = sleep_en && (cur_slot_ff == IDX_W'(k));
         cmd_w[k].prio   = prio_ff;
         cmd_w[k].ticks  = ticks_ff;
      end

      pts_cell #(
         .IDX_W    (IDX_W),
         .CELL_IDX (k)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd_w[k]),
         .cand_i     (cand_w[k]),
         .cand_idx_i (cidx_w[k]),
         .cand_o     (cand_w[k+1]),
         .cand_idx_o (cidx_w[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_operation;
         prio_ff  <= req_priority_req;
         ticks_ff <= req_sleep_ticks;
      end
      if (commit) begin
         rsp_status_ff        <= status_w;
         rsp_assigned_ff      <= (wr_en) ? 3'(slot_count_ff) : 3'd0;
         rsp_running_ff       <= 3'(cur_slot_in);
         rsp_running_valid_ff <= cur_valid_in;
         rsp_switched_ff      <= switched_w;
      end
      if (reset) begin
         fsm_ff        <= S_IDLE;
         wait_ff       <= '0;
         slot_count_ff <= '0;
         cur_slot_ff   <= '0;
         cur_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         fsm_ff        <= fsm_in;
         wait_ff       <= wait_in;
         slot_count_ff <= slot_count_in;
         cur_slot_ff   <= cur_slot_in;
         cur_valid_ff  <= cur_valid_in;
         rsp_valid_ff  <= commit;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_assigned_slot = rsp_assigned_ff;
   assign rsp_running_slot  = rsp_running_ff;
   assign rsp_running_valid = rsp_running_valid_ff;
   assign rsp_switched      = rsp_switched_ff;

   // a response beat only follows a command in flight
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(fsm_ff == S_WORK))
      else $error("response beat without a command in flight");

   // the current slot always lies inside the filled table
   a_cur_in_table: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> (CNT_W'(cur_slot_ff) < slot_count_ff))
      else $error("current slot outside the filled table");

   // an accepted command holds the block busy on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted command did not raise busy");

   // a schedule commits only after the block has already been in the work state
   a_sched_settled: assert property (@(posedge clock) disable iff (reset)
      (commit && op_ff == OP_SCHED) |-> $past(fsm_ff == S_WORK))
      else $error("schedule committed before the chain settled");

endmodule

// ===== rtl/pts_cell.sv =====
// One scheduler slot: state, priority, sleep counter and one scan stage.
module pts_cell #(
   parameter int unsigned IDX_W    = 3,
   parameter int unsigned CELL_IDX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pts_pkg::slot_cmd_type cmd,
   input  pts_pkg::scan_cand_type cand_i,
   input  logic [IDX_W-1:0]      cand_idx_i,
   output pts_pkg::scan_cand_type cand_o,
   output logic [IDX_W-1:0]      cand_idx_o
);
   import pts_pkg::*;

   logic [1:0]    state_ff, state_in;
   logic [7:0]    prio_ff, prio_in;
   logic [31:0]   count_ff, count_in;
   scan_cand_type cand_ff, cand_in;
   logic [IDX_W-1:0] cidx_ff, cidx_in;
   logic          win;

   always_comb begin
      state_in = state_ff;
      prio_in  = prio_ff;
      count_in = count_ff;
      priority if (cmd.wr) begin
         state_in = SLOT_READY;
         prio_in  = cmd.prio;
         count_in = '0;
      end else if (cmd.run) begin
         state_in = SLOT_RUNNING;
      end else if (cmd.unrun) begin
         if (state_ff == SLOT_RUNNING) state_in = SLOT_READY;
      end else if (cmd.sleep) begin
         state_in = SLOT_SLEEPING;
         count_in = cmd.ticks;
      end else if (cmd.tick && cmd.active && state_ff == SLOT_SLEEPING
                   && count_ff != '0) begin
         count_in = count_ff - 32'd1;
         if (count_ff == 32'd1) state_in = SLOT_READY;
      end
   end

   // lower priority wins; on a tie a slot past the current one beats a wrapped one
   always_comb begin
      win = cmd.active && (state_ff == SLOT_READY) &&
            (!cand_i.found || (prio_ff < cand_i.prio) ||
             ((prio_ff == cand_i.prio) && !cmd.late && cand_i.late));
      if (win) begin
         cand_in.found = 1'b1;
         cand_in.late  = cmd.late;
         cand_in.prio  = prio_ff;
         cidx_in       = IDX_W'(CELL_IDX);
      end else begin
         cand_in = cand_i;
         cidx_in = cand_idx_i;
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      prio_ff  <= prio_in;
      count_ff <= count_in;
      cidx_ff  <= cidx_in;
      if (reset) begin
         cand_ff <= '0;
      end else begin
         cand_ff <= cand_in;
      end
   end

   assign cand_o     = cand_ff;
   assign cand_idx_o = cidx_ff;

endmodule
